// ===== sv/frs_pkg.sv =====
// Shared constants, types and the stoichiometry table for the first-reaction SSA step block.
package frs_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int NUM_SPECIES   = 4;
    localparam int NUM_REACTIONS = 3;

    localparam int IO_COUNT_W = 16;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 40;
    localparam int VAR_W      = 32;
    localparam int FRAC_SHIFT = 16;
    localparam int NUM_W      = VAR_W + FRAC_SHIFT;
    localparam int PROP_W     = RATE_W + 2 * COUNT_WIDTH;
    localparam int RX_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TIME_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(6554);
    localparam logic [TIME_W-1:0] END_RESET  = TIME_W'(64'd16777216);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END  = 2'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FIRED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd3;

    // species slots
    localparam int SP_E  = 0;
    localparam int SP_S  = 1;
    localparam int SP_ES = 2;
    localparam int SP_P  = 3;

    // count change codes
    localparam logic [1:0] DLT_NONE = 2'd0;
    localparam logic [1:0] DLT_INC  = 2'd1;
    localparam logic [1:0] DLT_DEC  = 2'd2;

    // row = species (E, S, ES, P), column = reaction
    localparam logic [1:0] STOICH [NUM_SPECIES][NUM_REACTIONS] = '{
        '{DLT_DEC,  DLT_INC,  DLT_INC },
        '{DLT_DEC,  DLT_INC,  DLT_NONE},
        '{DLT_INC,  DLT_DEC,  DLT_DEC },
        '{DLT_NONE, DLT_NONE, DLT_INC }
    };

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [TIME_W-1:0]      t_time;
    typedef logic [RX_W-1:0]        t_rx;

    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic div_start;
        logic tau_take;
        logic apply;
        t_rx  rx;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic finished;
        logic prop_zero;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/frs_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module frs_div
    import frs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_numer,
    input  logic [PROP_W-1:0] i_denom,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROP_W-1:0] r_rem;
    logic [PROP_W-1:0] r_den;
    logic [NUM_W-1:0]  r_q;

    logic [PROP_W:0] trial;
    logic [PROP_W:0] diff;
    logic            ge;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // payload: numerator bits shift out the top as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_denom;
            r_q   <= i_numer;
        end else if (r_busy) begin
            r_rem <= ge ? diff[PROP_W-1:0] : trial[PROP_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/frs_dp.sv =====
// Datapath: species and time state, propensities, tau selection, update and output register.
module frs_dp
    import frs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_mode,
    input  logic [IO_COUNT_W-1:0] i_load_e,
    input  logic [IO_COUNT_W-1:0] i_load_s,
    input  logic [IO_COUNT_W-1:0] i_load_es,
    input  logic [IO_COUNT_W-1:0] i_load_p,
    input  logic [VAR_W-1:0]      i_variate_one,
    input  logic [VAR_W-1:0]      i_variate_two,
    input  logic [VAR_W-1:0]      i_variate_three,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [RX_W-1:0]       o_reaction_index,
    output logic [TIME_W-1:0]     o_time_now,
    output logic [IO_COUNT_W-1:0] o_count_e,
    output logic [IO_COUNT_W-1:0] o_count_s,
    output logic [IO_COUNT_W-1:0] o_count_es,
    output logic [IO_COUNT_W-1:0] o_count_p,
    output logic                  o_saturated
);

    logic [RATE_W-1:0] r_rate;
    t_time             r_end;
    t_count            r_count [NUM_SPECIES];
    t_time             r_sim_time;

    // captured item
    logic              r_mode;
    t_count            r_load [NUM_SPECIES];
    logic [VAR_W-1:0]  r_var [NUM_REACTIONS];

    logic [2*COUNT_WIDTH-1:0]    r_es_prod;
    logic [PROP_W-1:0]           r_prop0;
    logic [RATE_W+COUNT_WIDTH-1:0] r_prop1;

    logic  r_best_valid;
    t_rx   r_best_rx;
    t_time r_best_tau;
    logic  r_best_clip;

    logic r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [RX_W-1:0]       r_out_rx;
    t_time                 r_out_time;
    logic [IO_COUNT_W-1:0] r_out_count [NUM_SPECIES];
    logic                  r_out_sat;

    logic [NUM_W-1:0]  div_numer;
    logic [PROP_W-1:0] div_denom;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic              tau_clip;
    t_time             tau;
    logic              finished;

    logic [TIME_W:0]     t_sum;
    t_count              n_count [NUM_SPECIES];
    t_time               n_time;
    logic [STATUS_W-1:0] n_status;
    logic [RX_W-1:0]     n_rx;
    logic                n_sat;

    assign finished = (r_sim_time >= r_end);

    always_comb begin
        unique case (i_cmd.rx)
            2'd0:    div_numer = {r_var[0], {FRAC_SHIFT{1'b0}}};
            2'd1:    div_numer = {r_var[1], {FRAC_SHIFT{1'b0}}};
            default: div_numer = {r_var[2], {FRAC_SHIFT{1'b0}}};
        endcase
        div_denom = (i_cmd.rx == 2'd0) ? r_prop0 : PROP_W'(r_prop1);
    end

    frs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign tau_clip = |div_quot[NUM_W-1:TIME_W];
    assign tau      = tau_clip ? TIME_MAX : div_quot[TIME_W-1:0];

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.finished  = finished;
        o_stat.prop_zero = (div_denom == '0);
        o_stat.div_done  = div_done;
        o_stat.out_free  = !r_out_valid || i_ready;
    end

    // result of the item, taken on apply
    always_comb begin
        t_sum    = {1'b0, r_sim_time} + {1'b0, r_best_tau};
        n_time   = r_sim_time;
        n_status = ST_FIRED;
        n_rx     = '0;
        n_sat    = 1'b0;
        for (int i = 0; i < NUM_SPECIES; i++) begin
            n_count[i] = r_count[i];
        end
        if (!r_mode) begin
            for (int i = 0; i < NUM_SPECIES; i++) begin
                n_count[i] = r_load[i];
            end
            n_time   = '0;
            n_status = ST_LOADED;
        end else if (finished) begin
            n_status = ST_FINISHED;
        end else if (!r_best_valid) begin
            n_status = ST_NONE;
        end else begin
            n_rx  = r_best_rx;
            n_sat = r_best_clip;
            if (t_sum[TIME_W]) begin
                n_time = TIME_MAX;
                n_sat  = 1'b1;
            end else begin
                n_time = t_sum[TIME_W-1:0];
            end
            for (int i = 0; i < NUM_SPECIES; i++) begin
                unique case (STOICH[i][r_best_rx])
                    DLT_INC: begin
                        if (r_count[i] == {COUNT_WIDTH{1'b1}}) begin
                            n_sat = 1'b1;
                        end else begin
                            n_count[i] = r_count[i] + 1'b1;
                        end
                    end
                    DLT_DEC: begin
                        if (r_count[i] != '0) begin
                            n_count[i] = r_count[i] - 1'b1;
                        end
                    end
                    default: n_count[i] = r_count[i];
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= RATE_RESET;
            r_end        <= END_RESET;
            r_sim_time   <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_mode       <= 1'b0;
            for (int i = 0; i < NUM_SPECIES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RATE) begin
                    r_rate <= i_cfg_data[RATE_W-1:0];
                end else if (i_cfg_index == CFG_END) begin
                    r_end <= i_cfg_data[TIME_W-1:0];
                end
            end
            if (i_cmd.capture) begin
                r_mode       <= i_mode;
                r_best_valid <= 1'b0;
            end
            if (i_cmd.tau_take && (!r_best_valid || tau < r_best_tau)) begin
                r_best_valid <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_sim_time <= n_time;
                for (int i = 0; i < NUM_SPECIES; i++) begin
                    r_count[i] <= n_count[i];
                end
            end
            if (i_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_load[SP_E]  <= COUNT_WIDTH'(i_load_e);
            r_load[SP_S]  <= COUNT_WIDTH'(i_load_s);
            r_load[SP_ES] <= COUNT_WIDTH'(i_load_es);
            r_load[SP_P]  <= COUNT_WIDTH'(i_load_p);
            r_var[0]      <= i_variate_one;
            r_var[1]      <= i_variate_two;
            r_var[2]      <= i_variate_three;
        end
        if (i_cmd.mul1) begin
            r_es_prod <= r_count[SP_E] * r_count[SP_S];
            r_prop1   <= r_rate * r_count[SP_ES];
        end
        if (i_cmd.mul2) begin
            r_prop0 <= r_rate * r_es_prod;
        end
        if (i_cmd.tau_take && (!r_best_valid || tau < r_best_tau)) begin
            r_best_rx   <= i_cmd.rx;
            r_best_tau  <= tau;
            r_best_clip <= tau_clip;
        end
        if (i_cmd.apply) begin
            r_out_status <= n_status;
            r_out_rx     <= n_rx;
            r_out_time   <= n_time;
            r_out_sat    <= n_sat;
            for (int i = 0; i < NUM_SPECIES; i++) begin
                r_out_count[i] <= IO_COUNT_W'(n_count[i]);
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_reaction_index = r_out_rx;
    assign o_time_now       = r_out_time;
    assign o_count_e        = r_out_count[SP_E];
    assign o_count_s        = r_out_count[SP_S];
    assign o_count_es       = r_out_count[SP_ES];
    assign o_count_p        = r_out_count[SP_P];
    assign o_saturated      = r_out_sat;

endmodule

// ===== sv/frs_ctrl.sv =====
// Controller: sequences capture, propensity products, up to three divisions and the update.
module frs_ctrl
    import frs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL1   = 3'd2;
    localparam logic [2:0] S_MUL2   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_APPLY  = 3'd6;

    localparam t_rx RX_LAST = t_rx'(NUM_REACTIONS - 1);

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_rx        r_rx;
    t_rx        n_rx;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_rx    = r_rx;
        o_cmd   = '0;
        o_cmd.rx = r_rx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.mode || i_stat.finished) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.mul1 = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                n_rx    = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // zero propensity: reaction skipped, no division
                if (i_stat.prop_zero) begin
                    if (r_rx == RX_LAST) begin
                        n_state = S_APPLY;
                    end else begin
                        n_rx = r_rx + 1'b1;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.tau_take = 1'b1;
                    if (r_rx == RX_LAST) begin
                        n_state = S_APPLY;
                    end else begin
                        n_rx    = r_rx + 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_APPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rx    <= '0;
        end else begin
            r_state <= n_state;
            r_rx    <= n_rx;
        end
    end

endmodule

// ===== sv/first_reaction_ssa_step_top.sv =====
// Top level of the first-reaction SSA step block: controller plus datapath.
//
//  channel   direction  handshake                    payload
//  input     in         i_valid / o_ready            i_mode, i_load_*, i_variate_*
//  result    out        o_valid / i_ready            o_status .. o_saturated
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load item, or a step once time has reached end_time, goes from capture and decode
// straight to the update. A step forms the propensity products, then divides once per
// nonzero propensity, 48 iterations each on the single shared radix-2 divider.
// One item is in work at a time; the next is accepted once a result reaches the
// output register, even while it waits for i_ready. Synchronous reset clears
// counts and time and restores the register defaults; config writes always taken.
module first_reaction_ssa_step_top
    import frs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_mode,
    input  logic [IO_COUNT_W-1:0] i_load_e,
    input  logic [IO_COUNT_W-1:0] i_load_s,
    input  logic [IO_COUNT_W-1:0] i_load_es,
    input  logic [IO_COUNT_W-1:0] i_load_p,
    input  logic [VAR_W-1:0]      i_variate_one,
    input  logic [VAR_W-1:0]      i_variate_two,
    input  logic [VAR_W-1:0]      i_variate_three,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [RX_W-1:0]       o_reaction_index,
    output logic [TIME_W-1:0]     o_time_now,
    output logic [IO_COUNT_W-1:0] o_count_e,
    output logic [IO_COUNT_W-1:0] o_count_s,
    output logic [IO_COUNT_W-1:0] o_count_es,
    output logic [IO_COUNT_W-1:0] o_count_p,
    output logic                  o_saturated,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    frs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    frs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_load_e         (i_load_e),
        .i_load_s         (i_load_s),
        .i_load_es        (i_load_es),
        .i_load_p         (i_load_p),
        .i_variate_one    (i_variate_one),
        .i_variate_two    (i_variate_two),
        .i_variate_three  (i_variate_three),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_reaction_index (o_reaction_index),
        .o_time_now       (o_time_now),
        .o_count_e        (o_count_e),
        .o_count_s        (o_count_s),
        .o_count_es       (o_count_es),
        .o_count_p        (o_count_p),
        .o_saturated      (o_saturated)
    );

endmodule

// ===== test/frs_outcome_checker.sv =====
// Checker for the first-reaction SSA step block: predicts each result and compares it.
module frs_outcome_checker
    import frs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_mode,
    input  logic [IO_COUNT_W-1:0] i_load_e,
    input  logic [IO_COUNT_W-1:0] i_load_s,
    input  logic [IO_COUNT_W-1:0] i_load_es,
    input  logic [IO_COUNT_W-1:0] i_load_p,
    input  logic [VAR_W-1:0]      i_variate_one,
    input  logic [VAR_W-1:0]      i_variate_two,
    input  logic [VAR_W-1:0]      i_variate_three,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [RX_W-1:0]       i_reaction_index,
    input  logic [TIME_W-1:0]     i_time_now,
    input  logic [IO_COUNT_W-1:0] i_count_e,
    input  logic [IO_COUNT_W-1:0] i_count_s,
    input  logic [IO_COUNT_W-1:0] i_count_es,
    input  logic [IO_COUNT_W-1:0] i_count_p,
    input  logic                  i_saturated,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_fired,
    output int                    o_finished,
    output int                    o_stuck,
    output int                    o_clipped
);

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [RX_W-1:0]       rx;
        logic [TIME_W-1:0]     now;
        logic [IO_COUNT_W-1:0] e;
        logic [IO_COUNT_W-1:0] s;
        logic [IO_COUNT_W-1:0] es;
        logic [IO_COUNT_W-1:0] p;
        logic                  saturated;
    } t_outcome;

    // shadow of the block's state and registers
    t_count            counts [NUM_SPECIES];
    t_time             sim_clock;
    logic [RATE_W-1:0] rate_cfg;
    t_time             stop_time;

    t_outcome outcome_q [$];

    int mismatches = 0;
    int checked    = 0;
    int fired      = 0;
    int finished   = 0;
    int stuck      = 0;
    int clipped    = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = checked;
    assign o_fired      = fired;
    assign o_finished   = finished;
    assign o_stuck      = stuck;
    assign o_clipped    = clipped;

    function automatic logic [63:0] mul_clip(logic [63:0] a, logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return (prod[127:64] != '0) ? '1 : prod[63:0];
    endfunction

    // one load or one reaction step on the shadow state
    function automatic t_outcome advance_network(
        logic                                  is_step,
        logic [NUM_SPECIES-1:0][IO_COUNT_W-1:0] ld,
        logic [NUM_REACTIONS-1:0][VAR_W-1:0]    ev
    );
        t_outcome    r;
        logic [63:0] prop [NUM_REACTIONS];
        logic [63:0] num;
        logic [63:0] tau;
        logic [63:0] best_tau;
        logic [63:0] sum;
        int          best;
        logic        clip;
        r        = '0;
        best     = -1;
        best_tau = '0;
        if (!is_step) begin
            for (int k = 0; k < NUM_SPECIES; k++)
                counts[k] = t_count'(ld[k]);
            sim_clock = '0;
            r.status  = ST_LOADED;
        end else if (sim_clock >= stop_time) begin
            r.status = ST_FINISHED;
        end else begin
            prop[0] = mul_clip(64'(rate_cfg),
                               mul_clip(64'(counts[SP_E]), 64'(counts[SP_S])));
            prop[1] = mul_clip(64'(rate_cfg), 64'(counts[SP_ES]));
            prop[2] = prop[1];
            for (int k = 0; k < NUM_REACTIONS; k++) begin
                if (prop[k] != '0) begin
                    num  = {16'd0, ev[k], 16'd0};
                    tau  = num / prop[k];
                    clip = tau > 64'(TIME_MAX);
                    if (clip)
                        tau = 64'(TIME_MAX);
                    // strict compare: the lower index keeps a tie
                    if (best < 0 || tau < best_tau) begin
                        best        = k;
                        best_tau    = tau;
                        r.saturated = clip;
                    end
                end
            end
            if (best < 0) begin
                r.status = ST_NONE;
            end else begin
                sum = 64'(sim_clock) + best_tau;
                if (sum > 64'(TIME_MAX)) begin
                    sum         = 64'(TIME_MAX);
                    r.saturated = 1'b1;
                end
                sim_clock = sum[TIME_W-1:0];
                for (int k = 0; k < NUM_SPECIES; k++) begin
                    case (STOICH[k][best])
                        DLT_INC: begin
                            if (counts[k] == '1)
                                r.saturated = 1'b1;
                            else
                                counts[k] = counts[k] + 1'b1;
                        end
                        DLT_DEC: begin
                            if (counts[k] != '0)
                                counts[k] = counts[k] - 1'b1;
                        end
                        default: ;
                    endcase
                end
                r.status = ST_FIRED;
                r.rx     = RX_W'(best);
            end
        end
        r.now = sim_clock;
        r.e   = IO_COUNT_W'(counts[SP_E]);
        r.s   = IO_COUNT_W'(counts[SP_S]);
        r.es  = IO_COUNT_W'(counts[SP_ES]);
        r.p   = IO_COUNT_W'(counts[SP_P]);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            rate_cfg  = RATE_RESET;
            stop_time = END_RESET;
            sim_clock = '0;
            for (int k = 0; k < NUM_SPECIES; k++)
                counts[k] = '0;
            outcome_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RATE: rate_cfg  = i_cfg_data[RATE_W-1:0];
                    CFG_END:  stop_time = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing, so a stray result never meets this edge's item
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (outcome_q.size() == 0) begin
                    $error("result with no item outstanding: status %0d time 0x%0h",
                           i_status, i_time_now);
                    mismatches++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(want.status), 64'(i_status));
                    check_field("reaction_index", 64'(want.rx), 64'(i_reaction_index));
                    check_field("time_now", 64'(want.now), 64'(i_time_now));
                    check_field("count_e", 64'(want.e), 64'(i_count_e));
                    check_field("count_s", 64'(want.s), 64'(i_count_s));
                    check_field("count_es", 64'(want.es), 64'(i_count_es));
                    check_field("count_p", 64'(want.p), 64'(i_count_p));
                    check_field("saturated", 64'(want.saturated), 64'(i_saturated));
                    case (want.status)
                        ST_FIRED:    fired++;
                        ST_FINISHED: finished++;
                        ST_NONE:     stuck++;
                        default: ;
                    endcase
                    if (want.saturated)
                        clipped++;
                end
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(advance_network(i_mode,
                    {i_load_p, i_load_es, i_load_s, i_load_e},
                    {i_variate_three, i_variate_two, i_variate_one}));
        end
        o_pending <= outcome_q.size();
    end

endmodule

// ===== test/first_reaction_ssa_step_top_tb.sv =====
// Testbench top for the first-reaction SSA step block: stimulus, idling and verdict.
module first_reaction_ssa_step_top_tb;
    import frs_pkg::*;

    localparam logic        MODE_LOAD    = 1'b0;
    localparam logic        MODE_STEP    = 1'b1;
    localparam int          RANDOM_ITEMS = 540;
    localparam int          PHASE_ITEMS  = 90;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          TAIL_CYCLES  = 200;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef logic [NUM_SPECIES-1:0][IO_COUNT_W-1:0] t_loads;
    typedef logic [NUM_REACTIONS-1:0][VAR_W-1:0]    t_variates;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_valid         = 1'b0;
    logic                  i_mode          = MODE_LOAD;
    logic [IO_COUNT_W-1:0] i_load_e        = '0;
    logic [IO_COUNT_W-1:0] i_load_s        = '0;
    logic [IO_COUNT_W-1:0] i_load_es       = '0;
    logic [IO_COUNT_W-1:0] i_load_p        = '0;
    logic [VAR_W-1:0]      i_variate_one   = '0;
    logic [VAR_W-1:0]      i_variate_two   = '0;
    logic [VAR_W-1:0]      i_variate_three = '0;
    logic                  i_ready         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_RATE;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    logic                  o_ready;
    logic                  o_valid;
    logic                  o_cfg_ready;
    logic [STATUS_W-1:0]   o_status;
    logic [RX_W-1:0]       o_reaction_index;
    logic [TIME_W-1:0]     o_time_now;
    logic [IO_COUNT_W-1:0] o_count_e;
    logic [IO_COUNT_W-1:0] o_count_s;
    logic [IO_COUNT_W-1:0] o_count_es;
    logic [IO_COUNT_W-1:0] o_count_p;
    logic                  o_saturated;

    int fail_count;
    int pending;
    int checked;
    int fired;
    int finished;
    int stuck;
    int clipped;

    int burst_left  = 0;
    int hold_req    = 0;
    int hold_done   = 0;
    int loads_sent  = 0;
    int steps_sent  = 0;
    int settings    = 0;

    first_reaction_ssa_step_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_load_e         (i_load_e),
        .i_load_s         (i_load_s),
        .i_load_es        (i_load_es),
        .i_load_p         (i_load_p),
        .i_variate_one    (i_variate_one),
        .i_variate_two    (i_variate_two),
        .i_variate_three  (i_variate_three),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_reaction_index (o_reaction_index),
        .o_time_now       (o_time_now),
        .o_count_e        (o_count_e),
        .o_count_s        (o_count_s),
        .o_count_es       (o_count_es),
        .o_count_p        (o_count_p),
        .o_saturated      (o_saturated),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    frs_outcome_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_mode           (i_mode),
        .i_load_e         (i_load_e),
        .i_load_s         (i_load_s),
        .i_load_es        (i_load_es),
        .i_load_p         (i_load_p),
        .i_variate_one    (i_variate_one),
        .i_variate_two    (i_variate_two),
        .i_variate_three  (i_variate_three),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_status         (o_status),
        .i_reaction_index (o_reaction_index),
        .i_time_now       (o_time_now),
        .i_count_e        (o_count_e),
        .i_count_s        (o_count_s),
        .i_count_es       (o_count_es),
        .i_count_p        (o_count_p),
        .i_saturated      (o_saturated),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_fired          (fired),
        .o_finished       (finished),
        .o_stuck          (stuck),
        .o_clipped        (clipped)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_count pick_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return t_count'($urandom_range(1, 8));
            2, 3:    return t_count'($urandom_range(0, 300));
            4:       return t_count'($urandom);
            default: return t_count'($urandom_range(65530, 65535));
        endcase
    endfunction

    // mostly uniform Q8.24 values up to 4.0, with the extremes mixed in
    function automatic logic [VAR_W-1:0] pick_variate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            6:       return $urandom;
            7:       return VAR_W'($urandom_range(1, 1000));
            default: return VAR_W'($urandom_range(0, 32'h0400_0000));
        endcase
    endfunction

    task automatic send_item(input logic mode, input t_loads ld, input t_variates ev);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_load_e        <= ld[SP_E];
        i_load_s        <= ld[SP_S];
        i_load_es       <= ld[SP_ES];
        i_load_p        <= ld[SP_P];
        i_variate_one   <= ev[0];
        i_variate_two   <= ev[1];
        i_variate_three <= ev[2];
        do @(posedge i_clk); while (!o_ready);
        if (mode == MODE_LOAD)
            loads_sent++;
        else
            steps_sent++;
    endtask

    // variates ride along as junk on a load
    task automatic load_counts(input t_count e, input t_count s, input t_count es,
                               input t_count p);
        send_item(MODE_LOAD, {p, es, s, e}, {$urandom, $urandom, $urandom});
    endtask

    task automatic step_with(input logic [VAR_W-1:0] v1, input logic [VAR_W-1:0] v2,
                             input logic [VAR_W-1:0] v3);
        send_item(MODE_STEP, {$urandom, $urandom}, {v3, v2, v1});
    endtask

    task automatic await_results();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic program_regs(input logic [RATE_W-1:0] rate, input t_time stop);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_RATE;
        i_cfg_data  <= CFG_DATA_W'(rate);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_END;
        i_cfg_data  <= CFG_DATA_W'(stop);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int                random_sent;
        int                phase_end;
        int                phase;
        int                n;
        logic [RATE_W-1:0] rate;
        t_time             stop;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty network, saturating counts, ties
        step_with($urandom, $urandom, $urandom);
        load_counts('1, '1, '1, '1);
        step_with('0, '0, '0);
        step_with('1, '1, '1);
        load_counts('0, 16'd7, 16'd3, '0);
        step_with($urandom, 32'h0100_0000, 32'h0100_0000);
        step_with($urandom, 32'h0100_0000, 32'h00FF_FFFF);
        load_counts('0, '0, '0, '0);
        step_with('1, '1, '1);
        load_counts(16'd1, 16'd1, '0, '0);
        step_with(32'h0100_0000, '1, '1);
        await_results();

        // slowest rate, latest end: tau and time clipping, then finished
        program_regs(RATE_W'(1), TIME_MAX);
        load_counts('0, '0, 16'd1, '0);
        step_with($urandom, 32'h00FF_FFFF, '1);
        step_with(32'd2, '1, '1);
        step_with($urandom, $urandom, $urandom);
        load_counts('0, '0, 16'd1, '0);
        step_with($urandom, '1, '1);
        await_results();

        // fastest rate, earliest end: zero tau, then finished
        program_regs('1, TIME_W'(1));
        load_counts('1, '1, '0, 16'd9);
        step_with(32'd1, '1, '1);
        step_with('1, '1, '1);
        load_counts('0, '0, 16'd1, '0);
        step_with($urandom, 32'd1024, '1);
        step_with($urandom, $urandom, $urandom);
        await_results();

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       rate = RATE_W'(1);
                1:       rate = '1;
                2:       rate = RATE_RESET;
                3, 4:    rate = RATE_W'($urandom_range(1, 32'h0004_0000));
                default: rate = RATE_W'($urandom_range(1, 32'h00FF_FFFF));
            endcase
            case ($urandom_range(0, 5))
                0:       stop = TIME_W'(1);
                1:       stop = TIME_MAX;
                2:       stop = END_RESET;
                3:       stop = TIME_W'($urandom_range(1, 32'h1000_0000));
                4:       stop = TIME_W'({$urandom, $urandom});
                default: stop = TIME_W'($urandom_range(32'h0100_0000, 32'h4000_0000));
            endcase
            if (stop == '0)
                stop = TIME_W'(1);
            program_regs(rate, stop);
            if (phase == 0) begin
                // result side holds off while a back-to-back burst piles up
                hold_req   <= hold_req + 1;
                burst_left = 30;
            end
            phase_end = random_sent + PHASE_ITEMS;
            while (random_sent < phase_end) begin
                if ($urandom_range(0, 99) < 85) begin
                    load_counts(pick_count(), pick_count(), pick_count(), pick_count());
                    n = $urandom_range(1, 40);
                    repeat (n) step_with(pick_variate(), pick_variate(), pick_variate());
                    random_sent += n + 1;
                end else begin
                    send_item(1'($urandom_range(0, 1)), {$urandom, $urandom},
                              {$urandom, $urandom, $urandom});
                    random_sent++;
                end
            end
            await_results();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d loads and %0d steps under %0d register settings.",
                 loads_sent, steps_sent, settings + 1);
        $display("Checked %0d results: %0d fired, %0d past end time, %0d stuck, %0d saturated.",
                 checked, fired, finished, stuck, clipped);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : result_sink
        int style;
        int len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else begin
                style = $urandom_range(0, 3);
                len   = $urandom_range(1, 40);
                repeat (len) begin
                    case (style)
                        0:       i_ready <= 1'b1;
                        1:       i_ready <= ($urandom_range(0, 3) != 0);
                        2:       i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== first_reaction_ssa_step_top.f =====
sv/frs_pkg.sv
sv/frs_div.sv
sv/frs_dp.sv
sv/frs_ctrl.sv
sv/first_reaction_ssa_step_top.sv
test/frs_outcome_checker.sv
test/first_reaction_ssa_step_top_tb.sv
